[design/tsch_pkg.sv]
package tsch_pkg;

    localparam logic [1:0] OP_ARM   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [63:0] NEVER_DUE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TIME_TOP  = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [31:0] WAIT_TOP  = 32'h7FFF_FFFF;
    localparam logic [31:0] WAIT_NONE = 32'hFFFF_FFFF;

    localparam logic       KIND_EXPIRY = 1'b0;
    localparam logic       KIND_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input transaction
        logic do_update;   // apply arm or clear
        logic do_tick;     // advance the counter
        logic scan_start;  // reset the scan of the slot table
        logic scan_step;   // compare one slot
        logic emit_expiry; // load the output register with the found slot
        logic emit_query;  // load the output register with the wait answer
        logic last;        // flag the result as final
    } tsch_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_done;
        logic       found_due;
    } tsch_stat_t;

endpackage

[design/tsch_datapath.sv]
module tsch_datapath
    import tsch_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        s_opcode,
    input  logic [3:0]        s_slot,
    input  logic signed [31:0] s_delay_ms,
    input  logic [31:0]       s_payload,
    input  tsch_cmd_t         cmd,
    output tsch_stat_t        stat,
    output logic              m_kind,
    output logic [3:0]        m_expired_slot,
    output logic [31:0]       m_expired_payload,
    output logic signed [31:0] m_wait_ms,
    output logic              m_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [1:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [31:0] delay_reg;
    logic [31:0] pay_reg;
    logic [63:0] now_reg;
    logic [SLOTS-1:0] armed_reg;
    logic [63:0] due_reg [SLOTS];
    logic [31:0] spay_reg [SLOTS];

    logic [CW-1:0] scan_reg;
    logic          best_vld_reg;
    logic [IW-1:0] best_reg;
    logic [63:0]   best_due_reg;

    logic [IW-1:0] scan_idx;
    logic [IW-1:0] upd_idx;
    logic          slot_ok;
    logic [63:0]   sum;
    logic [63:0]   new_due;
    logic          cand;
    logic [63:0]   diff;

    assign scan_idx = scan_reg[IW-1:0];
    assign upd_idx  = IW'(slot_reg);
    assign slot_ok  = {28'd0, slot_reg} < 32'(SLOTS);
    assign sum      = now_reg + {32'd0, delay_reg};
    assign new_due  = delay_reg[31] ? NEVER_DUE :
                      ((sum < now_reg) || (sum > TIME_TOP)) ? TIME_TOP : sum;
    assign cand     = armed_reg[scan_idx] && (due_reg[scan_idx] != NEVER_DUE) &&
                      (!best_vld_reg || (due_reg[scan_idx] < best_due_reg));
    assign diff     = best_due_reg - now_reg;

    assign stat.opcode    = op_reg;
    assign stat.scan_done = (scan_reg == CW'(SLOTS));
    assign stat.found_due = best_vld_reg && (best_due_reg <= now_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg   <= '0;
            armed_reg <= '0;
            op_reg    <= OP_ARM;
            scan_reg  <= '0;
            best_vld_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                op_reg    <= s_opcode;
                slot_reg  <= s_slot;
                delay_reg <= s_delay_ms;
                pay_reg   <= s_payload;
            end
            if (cmd.do_update && slot_ok) begin
                if (op_reg == OP_ARM) begin
                    due_reg[upd_idx]   <= new_due;
                    spay_reg[upd_idx]  <= pay_reg;
                    armed_reg[upd_idx] <= 1'b1;
                end else begin
                    armed_reg[upd_idx] <= 1'b0;
                end
            end
            if (cmd.do_tick && (now_reg < TIME_TOP)) begin
                now_reg <= now_reg + 64'd1;
            end
            if (cmd.scan_start) begin
                scan_reg     <= '0;
                best_vld_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                scan_reg <= scan_reg + CW'(1);
                if (cand) begin
                    best_vld_reg <= 1'b1;
                    best_reg     <= scan_idx;
                    best_due_reg <= due_reg[scan_idx];
                end
            end
            if (cmd.emit_expiry) begin
                armed_reg[best_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_expiry) begin
            m_kind            <= KIND_EXPIRY;
            m_expired_slot    <= 4'(best_reg);
            m_expired_payload <= spay_reg[best_reg];
            m_wait_ms         <= '0;
            m_last            <= cmd.last;
        end else if (cmd.emit_query) begin
            m_kind            <= KIND_QUERY;
            m_expired_slot    <= '0;
            m_expired_payload <= '0;
            m_last            <= 1'b1;
            if (!best_vld_reg) begin
                m_wait_ms <= WAIT_NONE;
            end else if (best_due_reg <= now_reg) begin
                m_wait_ms <= '0;
            end else if (diff > {32'd0, WAIT_TOP}) begin
                m_wait_ms <= WAIT_TOP;
            end else begin
                m_wait_ms <= diff[31:0];
            end
        end
    end
endmodule

[design/tsch_ctrl.sv]
module tsch_ctrl
    import tsch_pkg::*;
#(
    parameter int MAX_RESULTS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  tsch_stat_t stat,
    output tsch_cmd_t  cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    logic [2:0]    state_reg, state_next;
    logic          mv_reg, mv_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          out_free;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cnt_next = '0;
                if (stat.opcode == OP_ARM || stat.opcode == OP_CLEAR) begin
                    cmd.do_update = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.do_tick    = (stat.opcode == OP_TICK);
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_DEC;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DEC: begin
                // A tick emits the due slot; the final flag waits until the
                // next scan shows nothing else is due.
                if (stat.opcode == OP_QUERY) begin
                    if (out_free) begin
                        cmd.emit_query = 1'b1;
                        mv_next        = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (stat.found_due && cnt_reg != NW'(MAX_RESULTS)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.emit_expiry = 1'b1;
                    cmd.scan_start  = 1'b1;
                    mv_next         = 1'b1;
                    cnt_next        = cnt_reg + NW'(1);
                    state_next      = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

[design/timeout_scheduler.sv]
// Timeout scheduler: a table of SLOTS timeout slots with a millisecond counter.
// The input channel (s_valid/s_ready) takes one opcode transaction at a time:
// arm, clear, tick or query. s_ready is high only while the block is idle, so
// one transaction ends before the next is taken.
// Arm and clear give no result.
// A query scans the table one slot a cycle and gives one result.
// A tick with k expiries gives k results. Each expiry is held one
// stage until the following scan decides whether it is the last one; m_last
// marks the final result of a transaction.
// When the receiver stalls, results wait in the output register and the hold
// stage, and the scan sequencer pauses until they move on.
// Reset (synchronous, aresetn low) disarms all slots and zeroes the counter.
// Slot due times and payloads are kept in registers and are not cleared.
module timeout_scheduler
    import tsch_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [3:0]         s_slot,
    input  logic signed [31:0] s_delay_ms,
    input  logic [31:0]        s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [3:0]         m_expired_slot,
    output logic [31:0]        m_expired_payload,
    output logic signed [31:0] m_wait_ms,
    output logic               m_last
);
    tsch_cmd_t  cmd;
    tsch_stat_t stat;
    logic       pv_reg;
    logic       p_kind_reg;
    logic [3:0] p_slot_reg;
    logic [31:0] p_pay_reg;
    logic signed [31:0] p_wait_reg;
    logic       p_last_reg;
    logic       dv;
    logic       d_ready;
    logic       d_kind, d_last;
    logic [3:0] d_slot;
    logic [31:0] d_pay;
    logic signed [31:0] d_wait;
    logic       held_reg;
    logic [3:0] h_slot_reg;
    logic [31:0] h_pay_reg;
    logic       u_ready;
    logic       c_valid;
    logic       c_ready;
    logic       take_d;
    logic       p_from_d;
    logic       flush;
    logic       p_load;

    // No new transaction is taken while an expiry still waits for its final flag.
    assign c_valid = s_valid && !held_reg;
    assign s_ready = c_ready && !held_reg;

    tsch_ctrl #(.MAX_RESULTS(16)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(c_valid), .s_ready(c_ready),
        .m_valid(dv), .m_ready(d_ready), .stat(stat), .cmd(cmd)
    );

    tsch_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_opcode(s_opcode), .s_slot(s_slot),
        .s_delay_ms(s_delay_ms), .s_payload(s_payload), .cmd(cmd), .stat(stat),
        .m_kind(d_kind), .m_expired_slot(d_slot), .m_expired_payload(d_pay),
        .m_wait_ms(d_wait), .m_last(d_last)
    );

    // The controller's expiries go into a one-deep hold stage. A held expiry
    // moves to the output register when the next expiry arrives (not final)
    // or when the controller is idle again (final). Query answers bypass it.
    assign u_ready  = !pv_reg || m_ready;
    assign d_ready  = u_ready || (!held_reg && (d_kind == KIND_EXPIRY));
    assign take_d   = dv && d_ready;
    assign p_from_d = take_d && (d_kind == KIND_QUERY);
    assign flush    = !take_d && held_reg && c_ready && u_ready;
    assign p_load   = p_from_d || (take_d && held_reg) || flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
            pv_reg   <= 1'b0;
        end else begin
            if (p_load) begin
                pv_reg <= 1'b1;
            end else if (m_ready) begin
                pv_reg <= 1'b0;
            end
            if (take_d && (d_kind == KIND_EXPIRY)) begin
                held_reg   <= 1'b1;
                h_slot_reg <= d_slot;
                h_pay_reg  <= d_pay;
            end else if (flush) begin
                held_reg <= 1'b0;
            end
            if (p_from_d) begin
                p_kind_reg <= d_kind;
                p_slot_reg <= d_slot;
                p_pay_reg  <= d_pay;
                p_wait_reg <= d_wait;
                p_last_reg <= d_last;
            end else if (p_load) begin
                p_kind_reg <= KIND_EXPIRY;
                p_slot_reg <= h_slot_reg;
                p_pay_reg  <= h_pay_reg;
                p_wait_reg <= '0;
                p_last_reg <= flush;
            end
        end
    end

    assign m_valid           = pv_reg;
    assign m_kind            = p_kind_reg;
    assign m_expired_slot    = p_slot_reg;
    assign m_expired_payload = p_pay_reg;
    assign m_wait_ms         = p_wait_reg;
    assign m_last            = p_last_reg;
endmodule
